// ===== hdl/stlg_pkg.sv =====
// ----------------------------------------------------------------------------
// stlg_pkg
// Shared widths, register indexes, wave codes and the quarter-sine table
// builder for the stereo tone generator.
// ----------------------------------------------------------------------------
package stlg_pkg;

    // Phase accumulator format: table address bits over fraction bits
    localparam int TABLE_ADDR_BITS = 12;
    localparam int PHASE_FRAC_BITS = 20;
    localparam int SAMPLE_BITS     = 16;
    localparam int ACC_BITS        = TABLE_ADDR_BITS + PHASE_FRAC_BITS;
    localparam int QTR_BITS        = TABLE_ADDR_BITS - 2;
    localparam int QTR_SIZE        = 1 << QTR_BITS;
    localparam int ROM_ADDR_BITS   = QTR_BITS + 1;
    localparam int MAG_BITS        = SAMPLE_BITS - 1;

    // Configuration port
    localparam int STEP_BITS     = 32;
    localparam int CFG_ADDR_BITS = 1;
    localparam int CFG_DATA_BITS = 32;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PHASE_STEP  = CFG_ADDR_BITS'(0);
    localparam logic [CFG_ADDR_BITS-1:0] REG_WAVE_SELECT = CFG_ADDR_BITS'(1);
    localparam logic [STEP_BITS-1:0]     STEP_RESET      = STEP_BITS'(89478485);

    // Wave codes; the unused code plays silence
    localparam int WAVE_BITS = 2;
    localparam logic [WAVE_BITS-1:0] WAVE_RECT   = 2'd0;
    localparam logic [WAVE_BITS-1:0] WAVE_SINE   = 2'd1;
    localparam logic [WAVE_BITS-1:0] WAVE_SILENT = 2'd2;

    // Peak amplitude and rectangle high level (clipped to the amplitude)
    localparam longint AMPLITUDE  = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint RECT_LEVEL = 30000;
    localparam logic [MAG_BITS-1:0] RECT_HIGH =
        MAG_BITS'((RECT_LEVEL > AMPLITUDE) ? AMPLITUDE : RECT_LEVEL);

    // Right channel phase after a restart: half or quarter of a table
    localparam logic [ACC_BITS-1:0] RIGHT_OFS_RECT = ACC_BITS'(1) << (ACC_BITS - 1);
    localparam logic [ACC_BITS-1:0] RIGHT_OFS_SINE = ACC_BITS'(1) << (ACC_BITS - 2);

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    typedef logic [MAG_BITS-1:0] qtr_rom_t [QTR_SIZE+1];

    // (a * b) >> sh over the full 128-bit product, low 64 bits kept
    function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b, int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p >> sh;
        return p[63:0];
    endfunction

    // sin(x) for x in [0, pi/2], Q62 in and out, Taylor series
    function automatic logic [63:0] sin_q62(logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = mul_shr(x, x, 62);
        term = x;
        sum  = x;
        for (int k = 1; k <= 16; k++) begin
            term = mul_shr(term, x2, 62) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    // Quarter wave, round half away from zero, evaluated at elaboration
    function automatic qtr_rom_t build_quarter_rom();
        qtr_rom_t    rom;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] v;
        for (int q = 0; q <= QTR_SIZE; q++) begin
            x = mul_shr(HALF_PI_Q62, 64'(q), QTR_BITS);
            s = sin_q62(x);
            v = (mul_shr(64'(AMPLITUDE), s, 61) + 64'd1) >> 1;
            if (v > 64'(AMPLITUDE)) begin
                v = 64'(AMPLITUDE);
            end
            rom[q] = v[MAG_BITS-1:0];
        end
        return rom;
    endfunction

endpackage

// ===== hdl/stlg_sine_rom.sv =====
// ----------------------------------------------------------------------------
// stlg_sine_rom
// Quarter-wave sine ROM with two synchronous read ports, one per channel.
// ----------------------------------------------------------------------------
module stlg_sine_rom (
    input  logic                                aclk,
    input  logic                                rd_en,
    input  logic [stlg_pkg::ROM_ADDR_BITS-1:0]  rd_addr_a,
    input  logic [stlg_pkg::ROM_ADDR_BITS-1:0]  rd_addr_b,
    output logic [stlg_pkg::MAG_BITS-1:0]       rd_data_a,
    output logic [stlg_pkg::MAG_BITS-1:0]       rd_data_b
);

    localparam stlg_pkg::qtr_rom_t ROM = stlg_pkg::build_quarter_rom();

    // Registered reads; data holds while the pipe is stalled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_a <= ROM[rd_addr_a];
            rd_data_b <= ROM[rd_addr_b];
        end
    end

endmodule

// ===== hdl/stereo_lut_tone_generator.sv =====
// ----------------------------------------------------------------------------
// stereo_lut_tone_generator
// Stereo DDS tone generator: phase accumulator, quarter-sine ROM and
// rectangle / silence selection, one stereo sample per request.
// ----------------------------------------------------------------------------
// Each input request yields one output request holding a left and a right
// sample. Throughput is one sample per clock unless m_tready stalls the
// output; a sample passes through the ROM read register, then the output
// register. The phase accumulators advance in the accept cycle, so
// back-to-back requests need no interlock. A restart bit reloads the phases
// (left at zero, right at half a table for the rectangle, a quarter for the
// sine) before that sample. Configuration writes are always accepted and
// must only be issued while no sample is in flight.
module stereo_lut_tone_generator (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input requests
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [0] restart
    // Output requests
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [2*stlg_pkg::SAMPLE_BITS-1:0]  m_tdata,   // right_sample (upper), left_sample (lower)
    // Configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [stlg_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [stlg_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

    localparam int ACC = stlg_pkg::ACC_BITS;
    localparam int TAB = stlg_pkg::TABLE_ADDR_BITS;
    localparam int QB  = stlg_pkg::QTR_BITS;
    localparam int SB  = stlg_pkg::SAMPLE_BITS;
    localparam int MB  = stlg_pkg::MAG_BITS;
    localparam int RAB = stlg_pkg::ROM_ADDR_BITS;
    localparam int WB  = stlg_pkg::WAVE_BITS;

    // Configuration registers
    logic [stlg_pkg::STEP_BITS-1:0] step_reg;
    logic [WB-1:0]                  wave_reg;

    // Phase accumulators
    logic [ACC-1:0] left_phase_reg,  left_phase_next;
    logic [ACC-1:0] right_phase_reg, right_phase_next;

    // Stage 1 (ROM data returning)
    logic          p1_valid_reg;
    logic [WB-1:0] p1_wave_reg;
    logic          p1_l_neg_reg, p1_r_neg_reg;
    logic          p1_l_hi_reg,  p1_r_hi_reg;

    // Output register
    logic          out_valid_reg;
    logic [SB-1:0] out_left_reg, out_right_reg;
    logic [SB-1:0] left_next, right_next;

    logic           pipe_en;
    logic           in_accept;
    logic           restart;
    logic [ACC-1:0] left_eff, right_eff, right_init;
    logic [TAB-1:0] left_idx, right_idx;
    logic [RAB-1:0] left_addr, right_addr;
    logic [MB-1:0]  left_mag, right_mag;

    // Pipe moves whenever the output register is free or being drained
    assign pipe_en   = !out_valid_reg || m_tready;
    assign s_tready  = pipe_en;
    assign in_accept = s_tvalid && pipe_en;
    assign restart   = s_tdata[0];
    assign cfg_ready = 1'b1;

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= stlg_pkg::STEP_RESET;
            wave_reg <= stlg_pkg::WAVE_RECT;
        end else if (cfg_valid) begin
            case (cfg_addr)
                stlg_pkg::REG_PHASE_STEP:  step_reg <= cfg_wdata[stlg_pkg::STEP_BITS-1:0];
                stlg_pkg::REG_WAVE_SELECT: wave_reg <= cfg_wdata[WB-1:0];
                default: ;
            endcase
        end
    end

    // Restart phase of the right channel follows the wave in use
    always_comb begin
        case (wave_reg)
            stlg_pkg::WAVE_RECT: right_init = stlg_pkg::RIGHT_OFS_RECT;
            stlg_pkg::WAVE_SINE: right_init = stlg_pkg::RIGHT_OFS_SINE;
            default:             right_init = '0;
        endcase
    end

    // Phases used for this sample, then advanced
    always_comb begin
        left_eff         = restart ? '0 : left_phase_reg;
        right_eff        = restart ? right_init : right_phase_reg;
        left_phase_next  = left_eff + ACC'(step_reg);
        right_phase_next = right_eff + ACC'(step_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_phase_reg  <= '0;
            right_phase_reg <= '0;
        end else if (in_accept) begin
            left_phase_reg  <= left_phase_next;
            right_phase_reg <= right_phase_next;
        end
    end

    // Table index and quadrant-mirrored ROM address
    assign left_idx  = left_eff[ACC-1 -: TAB];
    assign right_idx = right_eff[ACC-1 -: TAB];

    always_comb begin
        left_addr  = left_idx[QB] ?
                     RAB'(stlg_pkg::QTR_SIZE) - {1'b0, left_idx[QB-1:0]} :
                     {1'b0, left_idx[QB-1:0]};
        right_addr = right_idx[QB] ?
                     RAB'(stlg_pkg::QTR_SIZE) - {1'b0, right_idx[QB-1:0]} :
                     {1'b0, right_idx[QB-1:0]};
    end

    stlg_sine_rom u_rom (
        .aclk      (aclk),
        .rd_en     (pipe_en),
        .rd_addr_a (left_addr),
        .rd_addr_b (right_addr),
        .rd_data_a (left_mag),
        .rd_data_b (right_mag)
    );

    // Stage 1 control alongside the ROM read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            p1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            p1_wave_reg  <= wave_reg;
            p1_l_neg_reg <= left_idx[TAB-1];
            p1_r_neg_reg <= right_idx[TAB-1];
            p1_l_hi_reg  <= left_idx[TAB-1];
            p1_r_hi_reg  <= right_idx[TAB-1];
        end
    end

    // Wave shaping for one channel
    function automatic logic [SB-1:0] shape(logic [WB-1:0] wave, logic hi,
                                            logic neg, logic [MB-1:0] mag);
        logic [SB-1:0] res;
        case (wave)
            stlg_pkg::WAVE_RECT: res = hi ? {1'b0, stlg_pkg::RECT_HIGH} : '0;
            stlg_pkg::WAVE_SINE: res = neg ? -{1'b0, mag} : {1'b0, mag};
            default:             res = '0;
        endcase
        return res;
    endfunction

    assign left_next  = shape(p1_wave_reg, p1_l_hi_reg, p1_l_neg_reg, left_mag);
    assign right_next = shape(p1_wave_reg, p1_r_hi_reg, p1_r_neg_reg, right_mag);

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            out_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            out_left_reg  <= left_next;
            out_right_reg <= right_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_right_reg, out_left_reg};

endmodule
